/* hw/rtl/assert_macros.svh */
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m failed");
`endif

/* hw/rtl/vds_pkg.sv */
// ----------------------------------------------------------------------------
// vds_pkg
// types and constants for the vertex distance significance block
// ----------------------------------------------------------------------------
package vds_pkg;
  localparam int unsigned PosWidth = 24;
  localparam int unsigned CovWidth = 32;
  localparam int unsigned SigWidth = 32;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_COMPARE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                        cmd;
    logic signed [PosWidth-1:0]  pos_x;
    logic signed [PosWidth-1:0]  pos_y;
    logic signed [PosWidth-1:0]  pos_z;
    logic [CovWidth-2:0]         cov_xx;
    logic [CovWidth-2:0]         cov_yy;
    logic [CovWidth-2:0]         cov_zz;
    logic signed [CovWidth-1:0]  cov_xy;
    logic signed [CovWidth-1:0]  cov_xz;
    logic signed [CovWidth-1:0]  cov_yz;
  } in_beat_t;

  typedef struct packed {
    logic [SigWidth-1:0] significance;
    logic                sig_valid;
  } out_beat_t;
endpackage

/* hw/rtl/vertex_distance_significance.sv */
// ----------------------------------------------------------------------------
// vertex_distance_significance
// reference vertex store and distance significance pipeline
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// in       in   in_valid_i/in_stall_o  in_beat_i (in_beat_t)
// out      out  out_valid_o/out_stall_i out_beat_o (out_beat_t)
// one beat per cycle unless stalled, result via stages 1-5, sqrt_div, output
// load beats update the reference and leave the pipe with no result
// the whole pipe freezes while the output register is full and stalled
// reset clears the reference to zero and empties the pipe
module vertex_distance_significance (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vds_pkg::in_beat_t   in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vds_pkg::out_beat_t  out_beat_o
);
  import vds_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned DW  = PosWidth + 1;
  localparam int unsigned MW  = CovWidth + 1;
  localparam int unsigned AW  = DW + MW;
  localparam int unsigned UW  = AW + 2;
  localparam int unsigned UL  = UW / 2;
  localparam int unsigned UH  = UW - UL;
  localparam int unsigned QLW = DW + UL + 1;
  localparam int unsigned QHW = DW + UH;
  localparam int unsigned SW  = 2 * DW;
  localparam int unsigned DDW = 2 * DW;
  localparam int unsigned DL  = DDW / 2;
  localparam int unsigned DH  = DDW - DL;
  localparam int unsigned PPW = 2 * DH;
  localparam int unsigned QW  = DW + UW + 2;
  localparam int unsigned D2W = 2 * DDW;

  logic en;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic signed [PosWidth-1:0] rp_q [3];
  logic signed [CovWidth-1:0] rc_q [6];
  logic acc;
  assign acc = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) rp_q[i] <= '0;
      for (int i = 0; i < 6; i++) rc_q[i] <= '0;
    end else if (acc && in_beat_i.cmd == CMD_LOAD) begin
      rp_q[0] <= in_beat_i.pos_x;
      rp_q[1] <= in_beat_i.pos_y;
      rp_q[2] <= in_beat_i.pos_z;
      rc_q[0] <= CovWidth'(in_beat_i.cov_xx);
      rc_q[1] <= CovWidth'(in_beat_i.cov_yy);
      rc_q[2] <= CovWidth'(in_beat_i.cov_zz);
      rc_q[3] <= in_beat_i.cov_xy;
      rc_q[4] <= in_beat_i.cov_xz;
      rc_q[5] <= in_beat_i.cov_yz;
    end
  end

  // stage 1: difference and covariance sum
  logic v1_q;
  logic signed [DW-1:0] d1_q [3];
  logic signed [MW-1:0] m1_q [6];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= acc && in_beat_i.cmd == CMD_COMPARE;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q[0] <= DW'(in_beat_i.pos_x) - DW'(rp_q[0]);
      d1_q[1] <= DW'(in_beat_i.pos_y) - DW'(rp_q[1]);
      d1_q[2] <= DW'(in_beat_i.pos_z) - DW'(rp_q[2]);
      m1_q[0] <= MW'($signed({1'b0, in_beat_i.cov_xx})) + MW'(rc_q[0]);
      m1_q[1] <= MW'($signed({1'b0, in_beat_i.cov_yy})) + MW'(rc_q[1]);
      m1_q[2] <= MW'($signed({1'b0, in_beat_i.cov_zz})) + MW'(rc_q[2]);
      m1_q[3] <= MW'(in_beat_i.cov_xy) + MW'(rc_q[3]);
      m1_q[4] <= MW'(in_beat_i.cov_xz) + MW'(rc_q[4]);
      m1_q[5] <= MW'(in_beat_i.cov_yz) + MW'(rc_q[5]);
    end
  end

  // stage 2: covariance times difference, squared components
  logic v2_q;
  logic signed [AW-1:0] a2_q [3][3];
  logic signed [SW-1:0] s2_q [3];
  logic signed [DW-1:0] d2_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_q[0][0] <= AW'(m1_q[0]) * AW'(d1_q[0]);
      a2_q[0][1] <= AW'(m1_q[3]) * AW'(d1_q[1]);
      a2_q[0][2] <= AW'(m1_q[4]) * AW'(d1_q[2]);
      a2_q[1][0] <= AW'(m1_q[3]) * AW'(d1_q[0]);
      a2_q[1][1] <= AW'(m1_q[1]) * AW'(d1_q[1]);
      a2_q[1][2] <= AW'(m1_q[5]) * AW'(d1_q[2]);
      a2_q[2][0] <= AW'(m1_q[4]) * AW'(d1_q[0]);
      a2_q[2][1] <= AW'(m1_q[5]) * AW'(d1_q[1]);
      a2_q[2][2] <= AW'(m1_q[2]) * AW'(d1_q[2]);
      for (int i = 0; i < 3; i++) begin
        s2_q[i] <= SW'(d1_q[i]) * SW'(d1_q[i]);
      end
      d2_q <= d1_q;
    end
  end

  // stage 3: rows of m * d, squared distance
  logic v3_q;
  logic signed [UW-1:0] u3_q [3];
  logic [DDW-1:0] dd3_q;
  logic signed [DW-1:0] d3_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u3_q[i] <= UW'(a2_q[i][0]) + UW'(a2_q[i][1]) + UW'(a2_q[i][2]);
      end
      dd3_q <= DDW'(s2_q[0]) + DDW'(s2_q[1]) + DDW'(s2_q[2]);
      d3_q  <= d2_q;
    end
  end

  // stage 4: split products for d^T m d and for the squared distance squared
  logic v4_q, dnz4_q;
  logic signed [QLW-1:0] ql4_q [3];
  logic signed [QHW-1:0] qh4_q [3];
  logic [PPW-1:0] ddhh4_q, ddhl4_q, ddll4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ql4_q[i] <= QLW'(d3_q[i]) * QLW'($signed({1'b0, u3_q[i][UL-1:0]}));
        qh4_q[i] <= QHW'(d3_q[i]) * QHW'($signed(u3_q[i][UW-1:UL]));
      end
      ddhh4_q <= PPW'(dd3_q[DDW-1:DL]) * PPW'(dd3_q[DDW-1:DL]);
      ddhl4_q <= PPW'(dd3_q[DDW-1:DL]) * PPW'(dd3_q[DL-1:0]);
      ddll4_q <= PPW'(dd3_q[DL-1:0]) * PPW'(dd3_q[DL-1:0]);
      dnz4_q  <= dd3_q != '0;
    end
  end

  // stage 5: quadratic form and validity
  logic v5_q, ok5_q;
  logic signed [QW-1:0] qsum;
  logic [QW-1:0] q5_q;
  logic [D2W-1:0] dd5_q;
  assign qsum = QW'(ql4_q[0]) + QW'(ql4_q[1]) + QW'(ql4_q[2])
              + ((QW'(qh4_q[0]) + QW'(qh4_q[1]) + QW'(qh4_q[2])) <<< UL);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ok5_q <= dnz4_q && (qsum > 0);
      q5_q  <= qsum;
      dd5_q <= (D2W'(ddhh4_q) << (2*DL)) + (D2W'(ddhl4_q) << (DL+1)) + D2W'(ddll4_q);
    end
  end

  logic sq_valid;
  logic sq_ok;
  logic [SigWidth-1:0] sq_sig;
  vds_sqrt_div #(.QW(QW), .D2W(D2W)) u_sqrt_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q), .ok_i(ok5_q),
    .dd2_i(dd5_q), .q_i(q5_q), .valid_o(sq_valid), .sig_o(sq_sig), .ok_o(sq_ok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (en) out_valid_o <= sq_valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_beat_o.significance <= sq_sig;
      out_beat_o.sig_valid    <= sq_ok;
    end
  end

  `ASSERT_IMPL(a_stall_only_when_full, clk_i, rst_ni, !in_stall_o || out_valid_o)
  `ASSERT_NEXT(a_held_result, clk_i, rst_ni, out_valid_o && out_stall_i,
               out_valid_o && $stable(out_beat_o))
  `ASSERT_IMPL(a_invalid_zero, clk_i, rst_ni,
               !out_valid_o || out_beat_o.sig_valid || out_beat_o.significance == '0)
endmodule

/* hw/rtl/vds_sqrt_div.sv */
// ----------------------------------------------------------------------------
// vds_sqrt_div
// pipelined bit search: largest r with r^2 * q <= 2^32 * dd2, one bit a stage,
// remainder and r * q carried from stage to stage so no stage multiplies
// ----------------------------------------------------------------------------
module vds_sqrt_div #(
  parameter int unsigned QW  = 87,
  parameter int unsigned D2W = 100
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic                         ok_i,
  input  logic [D2W-1:0]               dd2_i,
  input  logic [QW-1:0]                q_i,
  output logic                         valid_o,
  output logic [vds_pkg::SigWidth-1:0] sig_o,
  output logic                         ok_o
);
  import vds_pkg::*;
  localparam int unsigned NS  = SigWidth;
  localparam int unsigned TW  = D2W + NS;
  localparam int unsigned RQW = QW + NS;
  localparam int unsigned LW  = RQW + NS + 1;

  logic [NS:0]          v_q;
  logic [NS:0]          ok_q;
  logic [NS:0][TW-1:0]  rem_q;
  logic [NS:0][RQW-1:0] rq_q;
  logic [NS:0][QW-1:0]  qq_q;
  logic [NS:0][NS-1:0]  r_q;

  // trial term for bit b: (r * q) << (b + 1) plus q << 2b
  logic [LW-1:0] delta [NS];
  logic [NS-1:0] take;

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      delta[s] = (LW'(rq_q[s]) << (NS - s)) + (LW'(qq_q[s]) << (2 * (NS - 1 - s)));
      take[s]  = delta[s] <= LW'(rem_q[s]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_q[0]  <= ok_i;
      qq_q[0]  <= q_i;
      rem_q[0] <= TW'(dd2_i) << NS;
      rq_q[0]  <= '0;
      r_q[0]   <= '0;
      for (int s = 0; s < NS; s++) begin
        ok_q[s+1]  <= ok_q[s];
        qq_q[s+1]  <= qq_q[s];
        rem_q[s+1] <= take[s] ? rem_q[s] - TW'(delta[s]) : rem_q[s];
        rq_q[s+1]  <= take[s] ? rq_q[s] + (RQW'(qq_q[s]) << (NS - 1 - s)) : rq_q[s];
        r_q[s+1]   <= take[s] ? r_q[s] | (NS'(1) << (NS - 1 - s)) : r_q[s];
      end
    end
  end

  assign valid_o = v_q[NS];
  assign ok_o    = ok_q[NS];
  assign sig_o   = ok_q[NS] ? r_q[NS] : '0;
endmodule
